>>> hw/rtl/lspa_pkg.sv
// Shared types and constants for the linked slot pool allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package lspa_pkg;

    localparam int SLOT_W    = 10;
    localparam int STATUS_W  = 3;
    localparam int LIMIT_W   = 11;
    localparam int TDATA_W   = 16;
    localparam int S_TUSER_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] RES_REUSED    = 3'd0;
    localparam logic [STATUS_W-1:0] RES_FRESH     = 3'd1;
    localparam logic [STATUS_W-1:0] RES_FREED     = 3'd2;
    localparam logic [STATUS_W-1:0] RES_EXHAUSTED = 3'd3;
    localparam logic [STATUS_W-1:0] RES_IGNORED   = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DECIDE,
        OP_REUSE,
        OP_UNLINK,
        OP_APPEND,
        OP_TERM,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic is_alloc;
        logic fp_valid;
        logic room;
        logic handle_ok;
        logic n_valid;
        logic out_free;
    } dp_status_t;

endpackage

>>> hw/rtl/lspa_ctrl.sv
// Sequencing controller for the linked slot pool allocator.
// Steps each request through the datapath operations; depends on lspa_pkg.
module lspa_ctrl
    import lspa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output op_t        op
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_REUSE,
        ST_UNLINK,
        ST_APPEND,
        ST_TERM,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op         = OP_LOAD;
                    state_next = ST_DECIDE;
                    ready_next = 1'b0;
                end
            end
            ST_DECIDE: begin
                op = OP_DECIDE;
                if (status.is_alloc) begin
                    if (status.fp_valid) begin
                        state_next = ST_REUSE;
                    end else if (status.room) begin
                        state_next = ST_APPEND;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else if (status.handle_ok) begin
                    state_next = ST_UNLINK;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_REUSE: begin
                op         = OP_REUSE;
                state_next = ST_FINISH;
            end
            ST_UNLINK: begin
                op         = OP_UNLINK;
                state_next = status.n_valid ? ST_APPEND : ST_TERM;
            end
            ST_APPEND: begin
                op         = OP_APPEND;
                state_next = ST_TERM;
            end
            ST_TERM: begin
                op         = OP_TERM;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    op         = OP_OUT;
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

>>> hw/rtl/lspa_datapath.sv
// Datapath of the linked slot pool allocator: link memories, list pointers,
// limit register and output register. Depends on lspa_pkg.
module lspa_datapath
    import lspa_pkg::*;
#(
    parameter int POOL_SLOTS = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  op_t                 op,
    input  logic                in_command,
    input  logic                in_present,
    input  logic [SLOT_W-1:0]   in_handle,
    input  logic                cfg_valid,
    input  logic [LIMIT_W-1:0]  cfg_data,
    input  logic                m_tready,
    output dp_status_t          status,
    output logic                m_tvalid,
    output logic [SLOT_W-1:0]   m_slot,
    output logic [STATUS_W-1:0] m_status
);

    localparam int SW   = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int LW   = $clog2(POOL_SLOTS + 1);
    localparam int CMPW = (LW > LIMIT_W) ? LW : LIMIT_W;
    localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);

    logic [LW-1:0] next_mem [POOL_SLOTS];
    logic [LW-1:0] prev_mem [POOL_SLOTS];

    logic                cmd_reg;
    logic                present_reg;
    logic [SLOT_W-1:0]   handle_reg;
    logic [SW-1:0]       tgt_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [SLOT_W-1:0]   m_slot_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic                m_valid_reg;

    logic [LIMIT_W-1:0]  limit_reg;
    logic [SW-1:0]       tail_reg;
    logic [LW-1:0]       fp_reg;
    logic [LW-1:0]       created_reg;
    logic                n0_nil_reg;
    logic                p0_nil_reg;
    logic                rdz_next_reg;
    logic                rdz_prev_reg;
    logic [LW-1:0]       rd_next_reg;
    logic [LW-1:0]       rd_prev_reg;

    logic          is_alloc;
    logic          fp_valid;
    logic [LW-1:0] n_eff;
    logic [LW-1:0] p_eff;
    logic          n_valid;
    logic          p_valid;
    logic [SW-1:0] next_raddr;
    logic [SW-1:0] prev_raddr;
    logic          nwe;
    logic [SW-1:0] nwaddr;
    logic [LW-1:0] nwdata;
    logic          pwe;
    logic [SW-1:0] pwaddr;
    logic [LW-1:0] pwdata;

    // Slot zero starts with both links null; the flags stand in for those entries.
    assign n_eff    = rdz_next_reg ? NIL : rd_next_reg;
    assign p_eff    = rdz_prev_reg ? NIL : rd_prev_reg;
    assign n_valid  = (n_eff != NIL);
    assign p_valid  = (p_eff != NIL);
    assign is_alloc = (cmd_reg == CMD_ALLOC);
    assign fp_valid = (fp_reg != NIL);

    assign next_raddr = is_alloc ? fp_reg[SW-1:0] : SW'(handle_reg);
    assign prev_raddr = SW'(handle_reg);

    always_comb begin
        status.is_alloc  = is_alloc;
        status.fp_valid  = fp_valid;
        status.room      = (CMPW'(created_reg) < CMPW'(limit_reg)) &&
                           (created_reg < NIL);
        status.handle_ok = present_reg && (CMPW'(handle_reg) < CMPW'(created_reg));
        status.n_valid   = n_valid;
        status.out_free  = !m_valid_reg || m_tready;
    end

    always_comb begin
        nwe    = 1'b0;
        nwaddr = tgt_reg;
        nwdata = NIL;
        pwe    = 1'b0;
        pwaddr = tgt_reg;
        pwdata = NIL;
        unique case (op)
            OP_UNLINK: begin
                nwe    = p_valid && n_valid;
                nwaddr = p_eff[SW-1:0];
                nwdata = n_eff;
                pwe    = n_valid;
                pwaddr = n_eff[SW-1:0];
                pwdata = p_eff;
            end
            OP_APPEND: begin
                nwe    = 1'b1;
                nwaddr = tail_reg;
                nwdata = LW'(tgt_reg);
                pwe    = 1'b1;
                pwaddr = tgt_reg;
                pwdata = LW'(tail_reg);
            end
            OP_TERM: begin
                nwe    = 1'b1;
                nwaddr = tgt_reg;
                nwdata = NIL;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (nwe) begin
            next_mem[nwaddr] <= nwdata;
        end
        rd_next_reg <= next_mem[next_raddr];
    end

    always_ff @(posedge aclk) begin
        if (pwe) begin
            prev_mem[pwaddr] <= pwdata;
        end
        rd_prev_reg <= prev_mem[prev_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= LIMIT_RESET;
            tail_reg     <= '0;
            fp_reg       <= '0;
            created_reg  <= LW'(1);
            n0_nil_reg   <= 1'b1;
            p0_nil_reg   <= 1'b1;
            rdz_next_reg <= 1'b0;
            rdz_prev_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (nwe && (nwaddr == '0)) begin
                n0_nil_reg <= 1'b0;
            end
            if (pwe && (pwaddr == '0)) begin
                p0_nil_reg <= 1'b0;
            end
            rdz_next_reg <= n0_nil_reg && (next_raddr == '0);
            rdz_prev_reg <= p0_nil_reg && (prev_raddr == '0);
            case (op)
                OP_REUSE: begin
                    fp_reg <= n_eff;
                end
                OP_APPEND: begin
                    tail_reg <= tgt_reg;
                end
                OP_TERM: begin
                    if (is_alloc) begin
                        created_reg <= created_reg + LW'(1);
                    end else if (!fp_valid) begin
                        fp_reg <= LW'(tgt_reg);
                    end
                end
                default: begin
                end
            endcase
            if (op == OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            OP_LOAD: begin
                cmd_reg     <= in_command;
                present_reg <= in_present;
                handle_reg  <= in_handle;
            end
            OP_DECIDE: begin
                tgt_reg        <= is_alloc ? created_reg[SW-1:0] : SW'(handle_reg);
                res_slot_reg   <= (is_alloc || !present_reg) ? '0 : handle_reg;
                res_status_reg <= is_alloc ? RES_EXHAUSTED : RES_IGNORED;
            end
            OP_REUSE: begin
                res_slot_reg   <= SLOT_W'(fp_reg);
                res_status_reg <= RES_REUSED;
            end
            OP_TERM: begin
                res_slot_reg   <= SLOT_W'(tgt_reg);
                res_status_reg <= is_alloc ? RES_FRESH : RES_FREED;
            end
            OP_OUT: begin
                m_slot_reg   <= res_slot_reg;
                m_status_reg <= res_status_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_slot   = m_slot_reg;
    assign m_status = m_status_reg;

endmodule

>>> hw/rtl/linked_slot_pool_allocator_core.sv
// Linked slot pool allocator, top level. One request at a time: an exhausted or ignored
// request needs only the decide step, a reuse adds a reuse step, a fresh slot append and
// term, a free of the tail slot unlink and term, and any other free unlink, append and
// term. These steps follow the single write port of each link memory.
// Synchronous active-low reset empties the pool to slot zero alone, free, limit 1024.
// Depends on lspa_pkg, lspa_ctrl and lspa_datapath.
module linked_slot_pool_allocator_core
    import lspa_pkg::*;
#(
    parameter int POOL_SLOTS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [9:0] handle
    input  logic [S_TUSER_W-1:0] s_tuser,   // [0] command, [1] handle_present
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [9:0] slot
    output logic [STATUS_W-1:0]  m_tuser,   // [2:0] status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [LIMIT_W-1:0]   cfg_data
);

    op_t               op;
    dp_status_t        status;
    logic [SLOT_W-1:0] m_slot;

    lspa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    lspa_datapath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op),
        .in_command (s_tuser[0]),
        .in_present (s_tuser[1]),
        .in_handle  (s_tdata[SLOT_W-1:0]),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .m_tready   (m_tready),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_slot     (m_slot),
        .m_status   (m_tuser)
    );

    assign cfg_ready = 1'b1;
    assign m_tdata   = {{(TDATA_W - SLOT_W){1'b0}}, m_slot};

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("reset did not leave the block ready and empty");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("a second request was taken while one is in work");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= RES_IGNORED))
        else $error("result carries an undefined status code");

    a_no_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && !m_tvalid) |=> !m_tvalid)
        else $error("a result appeared with no request in work");

endmodule

>>> dv/tb_linked_slot_pool_allocator_core.sv
// Self-checking testbench for linked_slot_pool_allocator_core, a fixed-size slot allocator.
// A built-in model of the slot list predicts every result; random bursts, gaps and stalls
// cover the stream handshakes. Depends on lspa_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_linked_slot_pool_allocator_core;
    import lspa_pkg::*;

    localparam int POOL = 1024;
    localparam logic [LIMIT_W-1:0] NO_LINK = LIMIT_W'(POOL);

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
    } alloc_result_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_LONG} rx_pattern_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [LIMIT_W-1:0]   cfg_data;

    logic [LIMIT_W-1:0] link_next [POOL];
    logic [LIMIT_W-1:0] link_prev [POOL];
    logic [LIMIT_W-1:0] list_tail;
    logic [LIMIT_W-1:0] free_ptr;
    logic [LIMIT_W-1:0] created;
    logic [LIMIT_W-1:0] slot_limit;

    alloc_result_t      pending_results[$];
    logic [SLOT_W-1:0]  held_slots[$];
    int                 mismatches;
    int                 burst_left;
    int                 rx_cycle;
    rx_pattern_t        rx_pattern;

    linked_slot_pool_allocator_core #(
        .POOL_SLOTS(POOL)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAIL linked_slot_pool_allocator_core");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 100) begin
            $display("%0t: mismatch: %s", $realtime, what);
        end
        mismatches++;
    endtask

    task automatic pool_reset();
        foreach (link_next[i]) begin
            link_next[i] = '0;
            link_prev[i] = '0;
        end
        link_next[0] = NO_LINK;
        link_prev[0] = NO_LINK;
        list_tail    = '0;
        free_ptr     = '0;
        created      = LIMIT_W'(1);
        slot_limit   = LIMIT_RESET;
    endtask

    task automatic append_at_tail(input logic [SLOT_W-1:0] s);
        if (list_tail < NO_LINK) begin
            link_next[list_tail[SLOT_W-1:0]] = LIMIT_W'(s);
        end
        link_prev[s] = list_tail;
        list_tail    = LIMIT_W'(s);
    endtask

    task automatic drop_held(input logic [SLOT_W-1:0] s);
        foreach (held_slots[i]) begin
            if (held_slots[i] == s) begin
                held_slots.delete(i);
                return;
            end
        end
    endtask

    // Applies one accepted request to the slot list and queues the result it must give.
    task automatic pool_step(input logic cmd, input logic present,
                             input logic [SLOT_W-1:0] handle);
        alloc_result_t      r;
        logic [LIMIT_W-1:0] cap;
        logic [LIMIT_W-1:0] p;
        logic [LIMIT_W-1:0] n;
        r.slot = '0;
        cap = (slot_limit > NO_LINK) ? NO_LINK : slot_limit;
        if (cmd == CMD_ALLOC) begin
            if (free_ptr < NO_LINK) begin
                r.slot   = free_ptr[SLOT_W-1:0];
                free_ptr = link_next[r.slot];
                r.status = RES_REUSED;
                held_slots.push_back(r.slot);
            end else if (created < cap) begin
                r.slot = created[SLOT_W-1:0];
                append_at_tail(r.slot);
                link_next[r.slot] = NO_LINK;
                created  = created + 1'b1;
                r.status = RES_FRESH;
                held_slots.push_back(r.slot);
            end else begin
                r.status = RES_EXHAUSTED;
            end
        end else if (!present) begin
            r.status = RES_IGNORED;
        end else if (LIMIT_W'(handle) >= created) begin
            r.slot   = handle;
            r.status = RES_IGNORED;
        end else begin
            p = link_prev[handle];
            n = link_next[handle];
            r.slot = handle;
            if (p < NO_LINK && n < NO_LINK) begin
                link_next[p[SLOT_W-1:0]] = n;
                link_prev[n[SLOT_W-1:0]] = p;
                append_at_tail(handle);
            end else if (n < NO_LINK) begin
                link_prev[n[SLOT_W-1:0]] = NO_LINK;
                append_at_tail(handle);
            end
            link_next[handle] = NO_LINK;
            if (!(free_ptr < NO_LINK)) begin
                free_ptr = LIMIT_W'(handle);
            end
            r.status = RES_FREED;
            drop_held(handle);
        end
        pending_results.push_back(r);
    endtask

    task automatic send_request(input logic cmd, input logic present,
                                input logic [SLOT_W-1:0] handle);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap        = $urandom_range(6, 1);
            burst_left = $urandom_range(24, 1);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W-SLOT_W){1'b0}}, handle};
        s_tuser  <= {present, cmd};
        do @(posedge aclk); while (!s_tready);
        pool_step(cmd, present, handle);
        burst_left--;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        slot_limit = value;
    endtask

    task automatic test_first_allocations();
        send_request(CMD_ALLOC, 1'b0, 10'h000);
        send_request(CMD_ALLOC, 1'b1, 10'h3FF);
        send_request(CMD_ALLOC, 1'b0, 10'h155);
        send_request(CMD_ALLOC, 1'b1, 10'h2AA);
    endtask

    task automatic test_ignored_frees();
        send_request(CMD_FREE, 1'b0, 10'h3FF);
        send_request(CMD_FREE, 1'b0, 10'h000);
        send_request(CMD_FREE, 1'b1, 10'h3FF);
        send_request(CMD_FREE, 1'b1, created[SLOT_W-1:0]);
    endtask

    // The limit drops below the slots already created, so only allocations by reuse can succeed.
    task automatic test_limit_one();
        write_limit(LIMIT_W'(1));
        send_request(CMD_ALLOC, 1'b0, 10'd0);
        send_request(CMD_FREE,  1'b1, 10'd2);
        send_request(CMD_FREE,  1'b1, 10'd0);
        send_request(CMD_FREE,  1'b1, 10'd0);
        send_request(CMD_FREE,  1'b1, 10'd3);
        send_request(CMD_ALLOC, 1'b0, 10'd0);
        send_request(CMD_ALLOC, 1'b1, 10'd0);
        send_request(CMD_ALLOC, 1'b0, 10'd0);
        send_request(CMD_ALLOC, 1'b0, 10'd0);
        send_request(CMD_FREE,  1'b1, 10'd1);
        send_request(CMD_FREE,  1'b1, 10'd1);
        send_request(CMD_ALLOC, 1'b0, 10'd0);
        send_request(CMD_ALLOC, 1'b0, 10'd0);
    endtask

    task automatic run_traffic(input logic [LIMIT_W-1:0] limit, input int count,
                               input int alloc_pct);
        int kind;
        logic [SLOT_W-1:0] h;
        write_limit(limit);
        repeat (count) begin
            h = SLOT_W'($urandom);
            if ($urandom_range(99) < alloc_pct) begin
                send_request(CMD_ALLOC, 1'($urandom), h);
            end else begin
                kind = $urandom_range(99);
                if (kind < 70 && held_slots.size() != 0) begin
                    h = held_slots[$urandom_range(held_slots.size() - 1)];
                    send_request(CMD_FREE, 1'b1, h);
                end else if (kind < 80) begin
                    h = SLOT_W'($urandom_range(int'(created) - 1));
                    send_request(CMD_FREE, 1'b1, h);
                end else if (kind < 90) begin
                    send_request(CMD_FREE, 1'b1, h);
                end else begin
                    send_request(CMD_FREE, 1'b0, h);
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(LIMIT_W'(16), 200, 55);
        run_traffic(LIMIT_W'(1024), 650, 93);
        run_traffic(LIMIT_W'(100), 120, 50);
        run_traffic(LIMIT_W'(1), 50, 40);
        run_traffic(LIMIT_W'(1023), 60, 70);
        run_traffic(LIMIT_W'($urandom_range(1024, 1)), 40, 60);
    endtask

    always @(posedge aclk) begin
        if (rx_cycle % 64 == 0) begin
            rx_pattern = rx_pattern_t'($urandom_range(3));
        end
        case (rx_pattern)
            RX_OPEN:  m_tready <= 1'b1;
            RX_COIN:  m_tready <= 1'($urandom);
            RX_THIRD: m_tready <= (rx_cycle % 3) != 0;
            default:  m_tready <= (rx_cycle % 16) >= 10;
        endcase
        rx_cycle++;
    end

    always @(posedge aclk) begin : check_results
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result slot %0d status %0d",
                                          m_tdata, m_tuser));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== {{(TDATA_W-SLOT_W){1'b0}}, want.slot}) begin
                    report_mismatch($sformatf("slot %0h, expected %0h", m_tdata, want.slot));
                end
                if (m_tuser !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tuser, want.status));
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        burst_left = 0;
        rx_cycle   = 0;
        rx_pattern = RX_OPEN;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        pool_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_first_allocations();
        test_ignored_frees();
        test_limit_one();
        test_random_traffic();
        wait_idle();
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS linked_slot_pool_allocator_core");
        end else begin
            $display("FAIL linked_slot_pool_allocator_core");
        end
        $finish;
    end

endmodule
